>>> rtl/cgb_pkg.sv
// Shared types, constants and helpers for the clipped glyph blit.
`default_nettype none

package cgb_pkg;

    localparam int GLYPH_MAX  = 256;
    localparam int SCREEN_MAX = 4096;

    localparam int COUNT_W  = $clog2(GLYPH_MAX);
    localparam int GEOM_W   = 9;
    localparam int COORD_W  = 13;
    localparam int POS_W    = COORD_W + 1;
    localparam int LEVEL_W  = 8;
    localparam int DIM_W    = 13;
    localparam int BPP_W    = 6;
    localparam int STRIDE_W = 15;
    localparam int OFFSET_W = 26;
    localparam int PROD_W   = COORD_W + STRIDE_W;
    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [BPP_W-1:0] BPP_8  = BPP_W'(8);
    localparam logic [BPP_W-1:0] BPP_16 = BPP_W'(16);
    localparam logic [BPP_W-1:0] BPP_32 = BPP_W'(32);

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2
    } wsize_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_BPP           = 2'd2,
        REG_LINE_STRIDE   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [LEVEL_W-1:0] level;
    } pixel_t;

    typedef struct packed {
        logic [DIM_W-1:0]    screen_width;
        logic [DIM_W-1:0]    screen_height;
        logic [BPP_W-1:0]    bpp;
        logic [STRIDE_W-1:0] line_stride;
    } cfg_t;

    function automatic logic [GEOM_W-1:0] cap_glyph(input logic [GEOM_W-1:0] g);
        cap_glyph = (g > GEOM_W'(GLYPH_MAX)) ? GEOM_W'(GLYPH_MAX) : g;
    endfunction

    function automatic logic [DIM_W-1:0] cap_screen(input logic [DIM_W-1:0] d);
        cap_screen = (d > DIM_W'(SCREEN_MAX)) ? DIM_W'(SCREEN_MAX) : d;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cgb_walk.sv
// Glyph walker: latches geometry, steps column/row counters, registers screen position.
`default_nettype none

module cgb_walk
    import cgb_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire logic               advance,
    input  wire logic               first,
    input  wire logic [COORD_W-1:0] origin_x,
    input  wire logic [COORD_W-1:0] origin_y,
    input  wire logic [GEOM_W-1:0]  glyph_width,
    input  wire logic [GEOM_W-1:0]  glyph_rows,
    input  wire logic [LEVEL_W-1:0] level,
    output pixel_t                  px,
    output logic                    px_valid
);

    logic [COUNT_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [COORD_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [GEOM_W-1:0]  wid_reg, wid_next, rows_reg, rows_next;
    logic [COUNT_W-1:0] col_cur, row_cur;
    pixel_t             px_reg, px_next;
    logic               valid_reg, valid_next;

    always_comb begin
        ox_next   = first ? origin_x : ox_reg;
        oy_next   = first ? origin_y : oy_reg;
        wid_next  = first ? cap_glyph(glyph_width) : wid_reg;
        rows_next = first ? cap_glyph(glyph_rows) : rows_reg;
        col_cur   = first ? '0 : col_reg;
        row_cur   = first ? '0 : row_reg;

        px_next.x     = POS_W'({ox_next[COORD_W-1], ox_next}) + POS_W'(col_cur);
        px_next.y     = POS_W'({oy_next[COORD_W-1], oy_next}) + POS_W'(row_cur);
        px_next.level = level;

        // down the column, then over to the next one
        if ((GEOM_W'(row_cur) + GEOM_W'(1)) >= rows_next) begin
            row_next = '0;
            if ((GEOM_W'(col_cur) + GEOM_W'(1)) >= wid_next) begin
                col_next = '0;
            end else begin
                col_next = col_cur + COUNT_W'(1);
            end
        end else begin
            row_next = row_cur + COUNT_W'(1);
            col_next = col_cur;
        end

        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            ox_reg    <= '0;
            oy_reg    <= '0;
            wid_reg   <= '0;
            rows_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (load) begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                ox_reg   <= ox_next;
                oy_reg   <= oy_next;
                wid_reg  <= wid_next;
                rows_reg <= rows_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            px_reg <= px_next;
        end
    end

    assign px       = px_reg;
    assign px_valid = valid_reg;

endmodule

`default_nettype wire

>>> rtl/cgb_pack.sv
// Pixel clip, framebuffer offset and RGB565 / byte packing.
`default_nettype none

module cgb_pack
    import cgb_pkg::*;
(
    input  wire pixel_t              px,
    input  wire cfg_t                cfg,
    output logic                     keep,
    output logic [OFFSET_W-1:0]      offset,
    output logic [LEVEL_W-1:0]       data,
    output wsize_t                   size
);

    logic                depth_ok, x_in, y_in;
    logic [OFFSET_W-1:0] x_off;
    logic [PROD_W-1:0]   row_off;

    always_comb begin
        x_in = !px.x[POS_W-1] && (px.x[COORD_W-1:0] < cap_screen(cfg.screen_width));
        y_in = !px.y[POS_W-1] && (px.y[COORD_W-1:0] < cap_screen(cfg.screen_height));

        depth_ok = 1'b1;
        data     = px.level;
        size     = SIZE_BYTE;
        x_off    = OFFSET_W'(px.x[COORD_W-1:0]);
        case (cfg.bpp)
            BPP_8: begin
                size = SIZE_BYTE;
            end
            BPP_16: begin
                // only blue survives the 565 pack
                data  = px.level >> 3;
                size  = SIZE_HALF;
                x_off = OFFSET_W'(px.x[COORD_W-1:0]) << 1;
            end
            BPP_32: begin
                size  = SIZE_WORD;
                x_off = OFFSET_W'(px.x[COORD_W-1:0]) << 2;
            end
            default: begin
                depth_ok = 1'b0;
            end
        endcase

        row_off = PROD_W'(px.y[COORD_W-1:0]) * PROD_W'(cfg.line_stride);
        offset  = row_off[OFFSET_W-1:0] + x_off;
        keep    = depth_ok && x_in && y_in;
    end

endmodule

`default_nettype wire

>>> rtl/clipped_glyph_blit_to_framebuffer_top.sv
// Clipped glyph blit: turns a column-major coverage stream into framebuffer writes.
//
// Input channel s_*: one coverage byte per request, column by column and down
// each column. A request with s_first set latches origin and glyph size and
// restarts the counters. Output channel m_*: one framebuffer write request
// (byte offset, data, access size) for each pixel that lands on screen at a
// supported depth; off-screen pixels and other depths produce nothing.
// An accepted request passes the input stage, which holds the screen position,
// and then the output register after the clip/offset logic. Throughput is
// one request per clock while m_ready is high; the output register frees up
// in the same cycle it is taken, so a full pipeline keeps s_ready high while
// m_ready is high. When m_ready is low the output holds and the input stage
// takes one more request only if it is empty, then s_ready drops.
// Configuration (cfg_*) is written one register per cycle; the user must do so
// only while idle, as the block does not enforce it. Reset clears both stages
// and the counters, and loads 800x480, 16 bpp, 1600-byte stride.
`default_nettype none

module clipped_glyph_blit_to_framebuffer_top
    import cgb_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_first,
    input  wire logic signed [COORD_W-1:0] s_origin_x,
    input  wire logic signed [COORD_W-1:0] s_origin_y,
    input  wire logic [GEOM_W-1:0]    s_glyph_width,
    input  wire logic [GEOM_W-1:0]    s_glyph_rows,
    input  wire logic [LEVEL_W-1:0]   s_level,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [OFFSET_W-1:0]       m_write_offset,
    output logic [LEVEL_W-1:0]        m_write_data,
    output logic [1:0]                m_write_size
);

    cfg_t                cfg_reg;
    pixel_t              px;
    logic                px_valid, advance, accept, keep;
    logic [OFFSET_W-1:0] offset, offset_reg;
    logic [LEVEL_W-1:0]  data, data_reg;
    wsize_t              size, size_reg;
    logic                out_valid_reg, out_valid_next;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !px_valid || advance;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.screen_width  <= DIM_W'(800);
            cfg_reg.screen_height <= DIM_W'(480);
            cfg_reg.bpp           <= BPP_16;
            cfg_reg.line_stride   <= STRIDE_W'(1600);
        end else if (cfg_wen) begin
            case (cfg_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_wdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_wdata[DIM_W-1:0];
                REG_BPP:           cfg_reg.bpp           <= cfg_wdata[BPP_W-1:0];
                REG_LINE_STRIDE:   cfg_reg.line_stride   <= cfg_wdata[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    cgb_walk u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept),
        .advance     (advance),
        .first       (s_first),
        .origin_x    (s_origin_x),
        .origin_y    (s_origin_y),
        .glyph_width (s_glyph_width),
        .glyph_rows  (s_glyph_rows),
        .level       (s_level),
        .px          (px),
        .px_valid    (px_valid)
    );

    cgb_pack u_pack (
        .px     (px),
        .cfg    (cfg_reg),
        .keep   (keep),
        .offset (offset),
        .data   (data),
        .size   (size)
    );

    always_comb begin
        if (advance) begin
            out_valid_next = px_valid && keep;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            offset_reg <= offset;
            data_reg   <= data;
            size_reg   <= size;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_write_offset = offset_reg;
    assign m_write_data   = data_reg;
    assign m_write_size   = size_reg;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the clipped glyph blit: directed and random pixel streams vs a predictor.
module tb_top;
    import cgb_pkg::*;

    typedef struct packed {
        logic                      first;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [GEOM_W-1:0]         glyph_width;
        logic [GEOM_W-1:0]         glyph_rows;
        logic [LEVEL_W-1:0]        level;
    } glyph_byte_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [LEVEL_W-1:0]  data;
        wsize_t              wsize;
    } fb_write_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_DROP,
        ROW_WRITE
    } row_mode_t;

    typedef struct {
        glyph_byte_t px;
        row_mode_t   mode;
        fb_write_t   wr;
    } dir_row_t;

    typedef struct {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [CFG_W-1:0] bpp;
        logic [CFG_W-1:0] stride;
        bit               rnd;
    } cfg_set_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wen = 1'b0;
    cfg_reg_t                  cfg_index = REG_SCREEN_WIDTH;
    logic [CFG_W-1:0]          cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_first = 1'b0;
    logic signed [COORD_W-1:0] s_origin_x = '0;
    logic signed [COORD_W-1:0] s_origin_y = '0;
    logic [GEOM_W-1:0]         s_glyph_width = '0;
    logic [GEOM_W-1:0]         s_glyph_rows = '0;
    logic [LEVEL_W-1:0]        s_level = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [OFFSET_W-1:0]       m_write_offset;
    logic [LEVEL_W-1:0]        m_write_data;
    logic [1:0]                m_write_size;

    // predictor copy of the registers and glyph state
    logic [DIM_W-1:0]          fb_width = DIM_W'(800);
    logic [DIM_W-1:0]          fb_height = DIM_W'(480);
    logic [BPP_W-1:0]          fb_bpp = BPP_16;
    logic [STRIDE_W-1:0]       fb_stride = STRIDE_W'(1600);
    logic signed [COORD_W-1:0] g_ox = '0;
    logic signed [COORD_W-1:0] g_oy = '0;
    int                        g_w = 0;
    int                        g_rows = 0;
    int                        g_col = 0;
    int                        g_row = 0;

    fb_write_t pending_writes [$];
    int        n_sent = 0;
    int        n_fail = 0;
    bit        tx_calm = 1'b0;
    bit        rx_calm = 1'b0;
    int        rx_wait;
    int        rx_hold = 0;

    dir_row_t dir_tab [19] = '{
        '{'{1'b0, 13'h0000, 13'h0000, 9'd0, 9'd0, 8'hff}, ROW_WRITE,
          '{26'd0, 8'h1f, SIZE_HALF}},
        '{'{1'b1, 13'h0000, 13'h0000, 9'd2, 9'd2, 8'h00}, ROW_WRITE,
          '{26'd0, 8'h00, SIZE_HALF}},
        '{'{1'b0, 13'h0000, 13'h0000, 9'd0, 9'd0, 8'hff}, ROW_WRITE,
          '{26'd1600, 8'h1f, SIZE_HALF}},
        '{'{1'b0, 13'h0000, 13'h0000, 9'd0, 9'd0, 8'h80}, ROW_WRITE,
          '{26'd2, 8'h10, SIZE_HALF}},
        '{'{1'b0, 13'h0000, 13'h0000, 9'd0, 9'd0, 8'h08}, ROW_WRITE,
          '{26'd1602, 8'h01, SIZE_HALF}},
        '{'{1'b0, 13'h0000, 13'h0000, 9'd0, 9'd0, 8'h07}, ROW_WRITE,
          '{26'd0, 8'h00, SIZE_HALF}},
        '{'{1'b1, 13'h1000, 13'h0000, 9'd1, 9'd1, 8'h55}, ROW_DROP,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b1, 13'h0fff, 13'h0fff, 9'd256, 9'd256, 8'haa}, ROW_DROP,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b1, 13'd799, 13'd479, 9'd2, 9'd2, 8'haa}, ROW_PREDICT,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b0, 13'h1555, 13'h0aaa, 9'h155, 9'h0aa, 8'h33}, ROW_DROP,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b0, 13'h0aaa, 13'h1555, 9'h0aa, 9'h155, 8'hcc}, ROW_DROP,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b0, 13'h0000, 13'h0000, 9'd0, 9'd0, 8'hf0}, ROW_DROP,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b1, 13'h1fff, 13'h1fff, 9'd511, 9'd300, 8'hff}, ROW_DROP,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b0, 13'h0000, 13'h0000, 9'd0, 9'd0, 8'h01}, ROW_DROP,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b1, 13'd0, 13'd479, 9'd0, 9'd0, 8'h5a}, ROW_PREDICT,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b0, 13'h0000, 13'h0000, 9'd0, 9'd0, 8'h5b}, ROW_PREDICT,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b1, 13'd10, 13'd20, 9'd3, 9'd1, 8'h7f}, ROW_PREDICT,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b0, 13'h0000, 13'h0000, 9'd0, 9'd0, 8'h40}, ROW_PREDICT,
          '{26'd0, 8'h00, SIZE_BYTE}},
        '{'{1'b0, 13'h0000, 13'h0000, 9'd0, 9'd0, 8'hc3}, ROW_PREDICT,
          '{26'd0, 8'h00, SIZE_BYTE}}
    };

    cfg_set_t phase_tab [8] = '{
        '{15'h7fff, 15'h7fff, 15'd32, 15'h7fff, 1'b0},
        '{15'd1, 15'd1, 15'd8, 15'd0, 1'b0},
        '{15'd4096, 15'd4096, 15'd16, 15'd16384, 1'b0},
        '{15'd0, 15'd0, 15'd0, 15'd0, 1'b1},
        '{15'd800, 15'd480, 15'd63, 15'd1600, 1'b0},
        '{15'd0, 15'd0, 15'd0, 15'd1, 1'b0},
        '{15'd0, 15'd0, 15'd0, 15'd0, 1'b1},
        '{15'd640, 15'd400, 15'd8, 15'd640, 1'b0}
    };

    clipped_glyph_blit_to_framebuffer_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first        (s_first),
        .s_origin_x     (s_origin_x),
        .s_origin_y     (s_origin_y),
        .s_glyph_width  (s_glyph_width),
        .s_glyph_rows   (s_glyph_rows),
        .s_level        (s_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_offset (m_write_offset),
        .m_write_data   (m_write_data),
        .m_write_size   (m_write_size)
    );

    always #5 aclk = ~aclk;

    // Computes the framebuffer write for one coverage byte and advances the glyph walk.
    function automatic bit blit_pixel(input glyph_byte_t px, output fb_write_t wr);
        int     x;
        int     y;
        int     nbytes;
        int     lim_w;
        int     lim_h;
        longint off;
        bit     depth_ok;
        if (px.first) begin
            g_ox   = px.origin_x;
            g_oy   = px.origin_y;
            g_w    = (px.glyph_width > GLYPH_MAX) ? GLYPH_MAX : int'(px.glyph_width);
            g_rows = (px.glyph_rows > GLYPH_MAX) ? GLYPH_MAX : int'(px.glyph_rows);
            g_col  = 0;
            g_row  = 0;
        end
        x = int'(g_ox) + g_col;
        y = int'(g_oy) + g_row;
        depth_ok = 1'b1;
        nbytes = 0;
        wr.data = px.level;
        case (fb_bpp)
            BPP_8: begin
                wr.wsize = SIZE_BYTE;
                nbytes = 1;
            end
            BPP_16: begin
                wr.data = px.level >> 3;
                wr.wsize = SIZE_HALF;
                nbytes = 2;
            end
            BPP_32: begin
                wr.wsize = SIZE_WORD;
                nbytes = 4;
            end
            default: begin
                wr.wsize = SIZE_BYTE;
                depth_ok = 1'b0;
            end
        endcase
        lim_w = (fb_width > SCREEN_MAX) ? SCREEN_MAX : int'(fb_width);
        lim_h = (fb_height > SCREEN_MAX) ? SCREEN_MAX : int'(fb_height);
        off = longint'(y) * longint'(fb_stride) + longint'(x) * longint'(nbytes);
        wr.offset = off[OFFSET_W-1:0];
        if (g_row + 1 >= g_rows) begin
            g_row = 0;
            g_col = (g_col + 1 >= g_w) ? 0 : g_col + 1;
        end else begin
            g_row = g_row + 1;
        end
        return depth_ok && x >= 0 && y >= 0 && x < lim_w && y < lim_h;
    endfunction

    // calm stretches: no idling at all
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic glyph_byte_t rand_byte();
        glyph_byte_t px;
        px.first       = 1'($urandom_range(0, 1));
        px.origin_x    = COORD_W'($urandom);
        px.origin_y    = COORD_W'($urandom);
        px.glyph_width = GEOM_W'($urandom);
        px.glyph_rows  = GEOM_W'($urandom);
        px.level       = LEVEL_W'($urandom);
        return px;
    endfunction

    // origin a little around the visible area
    function automatic logic signed [COORD_W-1:0] near_coord(input int lim);
        return COORD_W'($urandom_range(0, lim + 15) - 8);
    endfunction

    function automatic void check_write();
        fb_write_t want;
        if (pending_writes.size() == 0) begin
            $error("unexpected write request, offset %0d", m_write_offset);
            n_fail++;
            return;
        end
        want = pending_writes.pop_front();
        if (m_write_offset !== want.offset) begin
            $error("write_offset: expected %0d, got %0d", want.offset, m_write_offset);
            n_fail++;
        end
        if (m_write_data !== want.data) begin
            $error("write_data: expected %0h, got %0h", want.data, m_write_data);
            n_fail++;
        end
        if (m_write_size !== want.wsize) begin
            $error("write_size: expected %0d, got %0d", want.wsize, m_write_size);
            n_fail++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (m_valid && m_ready) begin
            check_write();
            rx_wait = draw_wait(rx_calm);
            m_ready <= (rx_wait == 0);
            rx_hold <= rx_wait;
        end else if (rx_hold > 0) begin
            m_ready <= (rx_hold == 1);
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_byte(input glyph_byte_t px);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_first       <= px.first;
        s_origin_x    <= px.origin_x;
        s_origin_y    <= px.origin_y;
        s_glyph_width <= px.glyph_width;
        s_glyph_rows  <= px.glyph_rows;
        s_level       <= px.level;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    task automatic push_pixel(input glyph_byte_t px);
        fb_write_t wr;
        send_byte(px);
        if (blit_pixel(px, wr)) pending_writes.push_back(wr);
    endtask

    // Mostly whole glyphs near the screen; some truncated, oversized or stray requests.
    task automatic random_glyph();
        glyph_byte_t px;
        int          kind;
        int          len;
        kind = $urandom_range(0, 99);
        px = rand_byte();
        if (kind < 12) begin
            push_pixel(px);
            return;
        end
        px.first = 1'b1;
        if (kind < 82) begin
            px.glyph_width = GEOM_W'($urandom_range(0, 8));
            px.glyph_rows  = GEOM_W'($urandom_range(0, 8));
            px.origin_x    = near_coord(int'(fb_width));
            px.origin_y    = near_coord(int'(fb_height));
            len = ((px.glyph_width == 0) ? 1 : int'(px.glyph_width)) *
                  ((px.glyph_rows == 0) ? 1 : int'(px.glyph_rows)) + $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
        end else if (kind < 99) begin
            len = $urandom_range(1, 24);
        end else begin
            px.glyph_width = GEOM_W'($urandom_range(1, 2));
            px.glyph_rows  = GEOM_W'($urandom_range(257, 511));
            px.origin_x    = near_coord(int'(fb_width));
            px.origin_y    = near_coord(int'(fb_height));
            len = GLYPH_MAX + $urandom_range(1, 8);
        end
        push_pixel(px);
        for (int i = 1; i < len; i++) begin
            px = rand_byte();
            px.first = 1'b0;
            push_pixel(px);
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_SCREEN_WIDTH:  fb_width = val[DIM_W-1:0];
            REG_SCREEN_HEIGHT: fb_height = val[DIM_W-1:0];
            REG_BPP:           fb_bpp = val[BPP_W-1:0];
            default:           fb_stride = val[STRIDE_W-1:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input cfg_set_t c);
        cfg_set_t v;
        v = c;
        if (c.rnd) begin
            v.width  = CFG_W'($urandom_range(1, 4096));
            v.height = CFG_W'($urandom_range(1, 4096));
            case ($urandom_range(0, 3))
                0:       v.bpp = CFG_W'(BPP_8);
                1:       v.bpp = CFG_W'(BPP_16);
                2:       v.bpp = CFG_W'(BPP_32);
                default: v.bpp = CFG_W'($urandom_range(0, 63));
            endcase
            v.stride = CFG_W'($urandom_range(1, 16384));
        end
        write_reg(REG_SCREEN_WIDTH, v.width);
        write_reg(REG_SCREEN_HEIGHT, v.height);
        write_reg(REG_BPP, v.bpp);
        write_reg(REG_LINE_STRIDE, v.stride);
        cfg_wen <= 1'b0;
    endtask

    // wait for all writes, then let the pipeline empty of dropped pixels
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    initial begin : stimulus
        fb_write_t wr;
        bit        hit;
        int        phase_start;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_tab[i]) begin
            send_byte(dir_tab[i].px);
            hit = blit_pixel(dir_tab[i].px, wr);
            case (dir_tab[i].mode)
                ROW_DROP:  hit = 1'b0;
                ROW_WRITE: begin
                    hit = 1'b1;
                    wr = dir_tab[i].wr;
                end
                default: ;
            endcase
            if (hit) pending_writes.push_back(wr);
        end
        for (int p = 0; p <= 8; p++) begin
            if (p > 0) begin
                drain();
                set_config(phase_tab[p-1]);
            end
            phase_start = n_sent;
            while (n_sent - phase_start < 80)
                random_glyph();
        end
        drain();
        if (n_fail == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cgb_pkg.sv
rtl/cgb_walk.sv
rtl/cgb_pack.sv
rtl/clipped_glyph_blit_to_framebuffer_top.sv
tb/tb_top.sv
